>>> src/trpd_pkg.sv
// Shared types and constants of the Targa run-length pixel decoder.
package trpd_pkg;

   // Depth of the queue between the byte decoder and the run output stage
   localparam int unsigned QueueDepth = 2;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CsrBytesPerPixel  = 2'd0,
      CsrRunLengthCoded = 2'd1,
      CsrPixelCount     = 2'd2
   } csr_index_type;

   // Field constants of the byte stream
   localparam logic [2:0] BppWithAlpha   = 3'd4;
   localparam logic [6:0] PacketCountMsk = 7'h7F;
   localparam int unsigned RepeatFlagBit = 7;

   // Reset values of the configuration registers
   localparam logic [2:0]  BppReset        = 3'd4;
   localparam logic        RleReset        = 1'b1;
   localparam logic [31:0] PixelCountReset = 32'd1;

   // Configuration as seen by the decoder
   typedef struct packed {
      logic        four;
      logic        rle;
      logic [31:0] pixel_count;
   } cfg_type;

   // One decoded run; red sits in the lowest bits
   typedef struct packed {
      logic [7:0] run_length;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } run_type;

endpackage

>>> src/trpd_front.sv
// Byte decoder: control bytes, pixel gathering and run generation.
module trpd_front (
   input  logic               clock,
   input  logic               reset,
   input  trpd_pkg::cfg_type  cfg_i,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,     // code_byte [7:0]
   input  logic               space_i,
   output logic               push_o,
   output trpd_pkg::run_type  run_o,
   output logic [31:0]        total_o
);

   logic        expect_control_ff, expect_control_in;
   logic        repeat_ff, repeat_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [23:0] pixel_ff, pixel_in;
   logic        started_ff, started_in;
   logic        halt_ff, halt_in;
   logic [31:0] total_ff, total_in;

   logic        accept;
   logic [1:0]  last_idx;
   logic [7:0]  packet_dec;

   assign req_tready = space_i;
   assign accept     = req_tvalid & space_i;
   assign last_idx   = cfg_i.four ? 2'd3 : 2'd2;
   assign packet_dec = (packet_left_ff != 8'd0) ? packet_left_ff - 8'd1 : 8'd0;
   assign total_o    = total_ff;

   // Decode one request byte
   always_comb begin
      expect_control_in = expect_control_ff;
      repeat_in         = repeat_ff;
      packet_left_in    = packet_left_ff;
      byte_idx_in       = byte_idx_ff;
      pixel_in          = pixel_ff;
      started_in        = started_ff;
      halt_in           = halt_ff;
      total_in          = total_ff;
      push_o            = 1'b0;
      run_o             = '0;

      if (accept && !halt_ff) begin
         // Latch the image size on the first byte
         if (!started_ff) begin
            started_in = 1'b1;
            total_in   = cfg_i.pixel_count;
         end
         if (!started_ff && cfg_i.pixel_count == 32'd0) begin
            halt_in = 1'b1;
         end else if (cfg_i.rle && expect_control_ff) begin
            repeat_in         = req_tdata[trpd_pkg::RepeatFlagBit];
            packet_left_in    = {1'b0, req_tdata[6:0] & trpd_pkg::PacketCountMsk} + 8'd1;
            expect_control_in = 1'b0;
            byte_idx_in       = 2'd0;
         end else if (byte_idx_ff < last_idx) begin
            // Gather blue, green and, with four bytes per pixel, red
            case (byte_idx_ff)
               2'd0:    pixel_in[7:0]   = req_tdata;
               2'd1:    pixel_in[15:8]  = req_tdata;
               2'd2:    pixel_in[23:16] = req_tdata;
               default: ;
            endcase
            byte_idx_in = byte_idx_ff + 2'd1;
         end else begin
            // Pixel complete: emit a run
            push_o      = 1'b1;
            byte_idx_in = 2'd0;
            run_o.blue  = pixel_ff[7:0];
            run_o.green = pixel_ff[15:8];
            if (cfg_i.four) begin
               run_o.red   = pixel_ff[23:16];
               run_o.alpha = req_tdata;
            end else begin
               run_o.red       = req_tdata;
               run_o.alpha     = 8'd0;
               pixel_in[23:16] = req_tdata;
            end
            run_o.run_length = 8'd1;
            if (cfg_i.rle) begin
               if (repeat_ff) begin
                  run_o.run_length  = (packet_left_ff == 8'd0) ? 8'd1 : packet_left_ff;
                  packet_left_in    = 8'd0;
                  expect_control_in = 1'b1;
               end else begin
                  packet_left_in = packet_dec;
                  if (packet_dec == 8'd0) begin
                     expect_control_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_control_ff <= 1'b1;
         repeat_ff         <= 1'b0;
         packet_left_ff    <= 8'd0;
         byte_idx_ff       <= 2'd0;
         pixel_ff          <= 24'd0;
         started_ff        <= 1'b0;
         halt_ff           <= 1'b0;
         total_ff          <= 32'd0;
      end else begin
         expect_control_ff <= expect_control_in;
         repeat_ff         <= repeat_in;
         packet_left_ff    <= packet_left_in;
         byte_idx_ff       <= byte_idx_in;
         pixel_ff          <= pixel_in;
         started_ff        <= started_in;
         halt_ff           <= halt_in;
         total_ff          <= total_in;
      end
   end

endmodule

>>> src/trpd_queue.sv
// Short run queue between the byte decoder and the output stage.
module trpd_queue #(
   parameter int unsigned QUEUE_DEPTH = trpd_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  trpd_pkg::run_type data_i,
   output logic              space_o,
   input  logic              pop_i,
   output logic              valid_o,
   output trpd_pkg::run_type data_o
);

   localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(QUEUE_DEPTH);

   trpd_pkg::run_type     slot_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign space_o = (count_ff != FullCount);
   assign valid_o = (count_ff != '0);
   assign data_o  = slot_ff[rd_ptr_ff];
   assign do_push = push_i & space_o;
   assign do_pop  = pop_i & valid_o;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed run
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_i;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue occupancy above depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("pushed run not counted");

endmodule

>>> src/trpd_back.sv
// Output stage: clip runs to the pixels left, mark the last run, drive the result.
module trpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  trpd_pkg::run_type run_i,
   input  logic [31:0]       total_i,
   output logic              pop_o,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,     // red, green, blue, alpha, run_length
   output logic              rsp_tlast      // last_pixel
);

   logic [31:0]       left_ff, left_in;
   logic              done_ff, done_in;
   logic              valid_ff, valid_in;
   trpd_pkg::run_type data_ff;
   logic              last_ff;

   logic [31:0]       left_cur;
   logic [7:0]        run_clip;
   logic [31:0]       left_next;
   logic              load;
   trpd_pkg::run_type run_load;

   assign pop_o     = valid_i & (done_ff | ~valid_ff | rsp_tready);
   assign load      = pop_o & ~done_ff;
   assign left_cur  = (left_ff == 32'd0) ? total_i : left_ff;
   assign run_clip  = ({24'd0, run_i.run_length} > left_cur) ? left_cur[7:0]
                                                             : run_i.run_length;
   assign left_next = left_cur - {24'd0, run_clip};

   // Replace the run length by the clipped one
   always_comb begin
      run_load            = run_i;
      run_load.run_length = run_clip;
   end

   // Count down the pixels left and hold the result register
   always_comb begin
      left_in  = left_ff;
      done_in  = done_ff;
      valid_in = valid_ff & ~rsp_tready;
      if (load) begin
         left_in  = left_next;
         done_in  = (left_next == 32'd0);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= 32'd0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= run_load;
         last_ff <= (left_next == 32'd0);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_last_sets_done: assert property (@(posedge clock) disable iff (reset)
      (load && left_next == 32'd0) |=> done_ff)
      else $error("last run did not end the image");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.run_length != 8'd0))
      else $error("result with empty run");

   a_no_load_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !load)
      else $error("result produced after image end");

endmodule

>>> src/tga_rle_pixel_decoder_unit.sv
// Top level of the Targa run-length pixel decoder.
//
// The request channel takes one byte of Targa image data per accepted
// request (req_tvalid and req_tready high at a rising clock edge). The
// decoder reads control bytes in run-length mode, gathers 3 or 4 byte
// pixels and emits one run per finished pixel or repeat packet on the
// response channel: colors in red-green-blue-alpha order, the run length,
// and rsp_tlast on the run that ends the image. Bytes after that run, and
// every byte of an image whose pixel count is zero, give no response.
// The csr port writes bytes per pixel, run-length mode and pixel count.
// Write them only while the stream is idle; the block does not enforce it.
// A pixel's final byte is decoded combinationally; its run is registered
// in the run queue and then in the output register that drives rsp_tvalid.
// Throughput: one byte per cycle while the run queue has space.
// A stalled response channel fills the run queue and the output
// register; req_tready then drops until the result is taken.
// Reset (synchronous, active high) restores 4 bytes per pixel, run-length
// mode and a pixel count of one, and starts a new image.
module tga_rle_pixel_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = trpd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // code_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // red, green, blue, alpha, run_length
   output logic        rsp_tlast,     // last_pixel
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [2:0]        bpp_ff;
   logic              rle_ff;
   logic [31:0]       count_ff;
   trpd_pkg::cfg_type cfg;

   logic              space;
   logic              push;
   trpd_pkg::run_type push_run;
   logic [31:0]       total;
   logic              q_valid;
   trpd_pkg::run_type q_run;
   logic              pop;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= trpd_pkg::BppReset;
         rle_ff   <= trpd_pkg::RleReset;
         count_ff <= trpd_pkg::PixelCountReset;
      end else if (csr_we) begin
         case (trpd_pkg::csr_index_type'(csr_index))
            trpd_pkg::CsrBytesPerPixel:  bpp_ff   <= csr_wdata[2:0];
            trpd_pkg::CsrRunLengthCoded: rle_ff   <= csr_wdata[0];
            trpd_pkg::CsrPixelCount:     count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.four        = (bpp_ff == trpd_pkg::BppWithAlpha);
   assign cfg.rle         = rle_ff;
   assign cfg.pixel_count = count_ff;

   trpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .space_i    (space),
      .push_o     (push),
      .run_o      (push_run),
      .total_o    (total)
   );

   trpd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (push_run),
      .space_o (space),
      .pop_i   (pop),
      .valid_o (q_valid),
      .data_o  (q_run)
   );

   trpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (q_valid),
      .run_i      (q_run),
      .total_i    (total),
      .pop_o      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/tb.sv
// Self-checking bench for the Targa run-length pixel decoder unit.
`timescale 1ns / 100ps

module tb;

   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned SettleCycles = 4;
   localparam int unsigned DrainFloor   = 300;

   // One decoded run plus the end-of-image flag
   typedef struct packed {
      trpd_pkg::run_type px;
      logic              last_pixel;
   } pixel_run_type;

   // Directed stimulus row
   typedef struct {
      logic [7:0]    code;
      bit            typed;
      pixel_run_type run;
   } code_row_type;

   // Random traffic segment with its register setting and flow control
   typedef struct {
      logic [2:0]  bpp;
      logic        rle;
      logic [31:0] pix_count;
      int          idle_pct;
      int          stall_pct;
      int          n_codes;
      int          hold;
   } segment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Decoder image as predicted by the bench
   logic [2:0]  cfg_bpp;
   logic        cfg_rle;
   logic [31:0] cfg_pix_count;
   logic        awaiting_control;
   logic        rpt_packet;
   logic [7:0]  packet_left;
   logic [1:0]  byte_in_pixel;
   logic [23:0] pixel_bytes;
   logic [31:0] pixels_left;
   logic        image_done;

   pixel_run_type pending_runs[$];
   int            failures = 0;
   int            codes_sent = 0;
   int            runs_checked = 0;
   int            repeat_runs = 0;
   int            clipped_runs = 0;
   int            idle_pct = 0;
   int            stall_pct = 0;
   logic          holding = 1'b0;
   int unsigned   cycle_count = 0;

   tga_rle_pixel_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb NOT OK");
         $finish;
      end
   end

   // Advance the predicted decoder by one code byte; return 1 when a run comes out
   function automatic bit decode_code(input logic [7:0] b, output pixel_run_type r);
      logic        four;
      logic [1:0]  last_index;
      logic [7:0]  alpha;
      logic [31:0] run;
      four       = (cfg_bpp == trpd_pkg::BppWithAlpha);
      last_index = four ? 2'd3 : 2'd2;
      alpha      = '0;
      r          = '0;
      if (image_done)
         return 1'b0;
      // load the pixel total on the first byte of the image
      if (pixels_left == 0) begin
         pixels_left = cfg_pix_count;
         if (pixels_left == 0) begin
            image_done = 1'b1;
            return 1'b0;
         end
      end
      if (cfg_rle && awaiting_control) begin
         rpt_packet       = b[trpd_pkg::RepeatFlagBit];
         packet_left      = {1'b0, b[6:0] & trpd_pkg::PacketCountMsk} + 8'd1;
         awaiting_control = 1'b0;
         byte_in_pixel    = '0;
         return 1'b0;
      end
      // gather blue, green and, with four bytes per pixel, red
      if (byte_in_pixel < last_index) begin
         pixel_bytes[8*byte_in_pixel +: 8] = b;
         byte_in_pixel = byte_in_pixel + 2'd1;
         return 1'b0;
      end
      if (four)
         alpha = b;
      else
         pixel_bytes[23:16] = b;
      byte_in_pixel = '0;
      run = 1;
      if (cfg_rle) begin
         if (rpt_packet) begin
            run = (packet_left == 0) ? 1 : packet_left;
            packet_left      = '0;
            awaiting_control = 1'b1;
         end else begin
            if (packet_left > 0)
               packet_left = packet_left - 8'd1;
            if (packet_left == 0)
               awaiting_control = 1'b1;
         end
      end
      // clip the final run to the pixels left
      if (run > pixels_left)
         run = pixels_left;
      pixels_left = pixels_left - run;
      r.px.red        = pixel_bytes[23:16];
      r.px.green      = pixel_bytes[15:8];
      r.px.blue       = pixel_bytes[7:0];
      r.px.alpha      = alpha;
      r.px.run_length = run[7:0];
      r.last_pixel    = (pixels_left == 0);
      if (pixels_left == 0)
         image_done = 1'b1;
      return 1'b1;
   endfunction

   // Write all three registers back to back while the stream is quiet
   task automatic configure(input logic [2:0] bpp, input logic rle, input logic [31:0] pc);
      csr_we    <= 1'b1;
      csr_index <= trpd_pkg::CsrBytesPerPixel;
      csr_wdata <= {29'd0, bpp};
      @(posedge clock);
      cfg_bpp   = bpp;
      csr_index <= trpd_pkg::CsrRunLengthCoded;
      csr_wdata <= {31'd0, rle};
      @(posedge clock);
      cfg_rle   = rle;
      csr_index <= trpd_pkg::CsrPixelCount;
      csr_wdata <= pc;
      @(posedge clock);
      cfg_pix_count = pc;
      csr_we    <= 1'b0;
   endtask

   // Offer one code byte, wait for the handshake and record what it should produce
   task automatic send_code(input logic [7:0] b, input bit typed,
                            input pixel_run_type typed_run);
      pixel_run_type r;
      int            gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do
         @(posedge clock);
      while (!req_tready);
      codes_sent++;
      if (decode_code(b, r)) begin
         if (r.px.run_length > 1)
            repeat_runs++;
         if (r.last_pixel && r.px.run_length != 128 && rpt_packet)
            clipped_runs++;
         pending_runs.push_back(typed ? typed_run : r);
      end
   endtask

   // Drop valid, then hold until every predicted run has been taken
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_runs.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Hold the receiver off for a counted stretch of cycles
   task automatic hold_receiver(input int n);
      holding <= 1'b1;
      repeat (n) @(posedge clock);
      holding <= 1'b0;
   endtask

   // Pick the next byte so that packets stay well formed with random content
   function automatic logic [7:0] next_code(input bit force_repeat);
      logic [7:0] b;
      if (cfg_rle && awaiting_control) begin
         if (force_repeat)
            b = 8'hFF;
         else if ($urandom_range(0, 1))
            b = {1'b1, 7'($urandom_range(0, 127))};
         else if ($urandom_range(0, 19) == 0)
            b = {1'b0, 7'($urandom_range(0, 127))};
         else
            b = {1'b0, 7'($urandom_range(0, 7))};
      end else begin
         case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
      end
      return b;
   endfunction

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   // Take runs from the response channel and compare them with the oldest prediction
   always @(posedge clock) begin
      pixel_run_type got;
      pixel_run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.px         = rsp_tdata;
         got.last_pixel = rsp_tlast;
         if (pending_runs.size() == 0) begin
            $error("run with no prediction waiting: tdata %h last %b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = pending_runs.pop_front();
            check_field("red", want.px.red, got.px.red);
            check_field("green", want.px.green, got.px.green);
            check_field("blue", want.px.blue, got.px.blue);
            check_field("alpha", want.px.alpha, got.px.alpha);
            check_field("run_length", want.px.run_length, got.px.run_length);
            check_field("last_pixel", want.last_pixel, got.last_pixel);
            runs_checked++;
         end
      end
      // hold off during a long stretch, else stall at random
      if (holding)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      code_row_type  rows[24];
      segment_type   segs[6];
      pixel_run_type none;
      logic [31:0]   image_pixels;
      int            k;

      none = '0;
      // predicted reset state
      cfg_bpp          = trpd_pkg::BppReset;
      cfg_rle          = trpd_pkg::RleReset;
      cfg_pix_count    = trpd_pkg::PixelCountReset;
      awaiting_control = 1'b1;
      rpt_packet       = 1'b0;
      packet_left      = '0;
      byte_in_pixel    = '0;
      pixel_bytes      = '0;
      pixels_left      = '0;
      image_done       = 1'b0;

      // repeat 128, raw 1, raw 2, repeat 1; pixels as blue, green, red, alpha
      rows[0]  = '{8'hFF, 1'b0, none};
      rows[1]  = '{8'h00, 1'b0, none};
      rows[2]  = '{8'hFF, 1'b0, none};
      rows[3]  = '{8'h80, 1'b0, none};
      rows[4]  = '{8'h01, 1'b1, '{'{8'd128, 8'h01, 8'h00, 8'hFF, 8'h80}, 1'b0}};
      rows[5]  = '{8'h00, 1'b0, none};
      rows[6]  = '{8'hFF, 1'b0, none};
      rows[7]  = '{8'h00, 1'b0, none};
      rows[8]  = '{8'h7F, 1'b0, none};
      rows[9]  = '{8'hFF, 1'b1, '{'{8'd1, 8'hFF, 8'hFF, 8'h00, 8'h7F}, 1'b0}};
      rows[10] = '{8'h01, 1'b0, none};
      rows[11] = '{8'h55, 1'b0, none};
      rows[12] = '{8'hAA, 1'b0, none};
      rows[13] = '{8'h33, 1'b0, none};
      rows[14] = '{8'hCC, 1'b0, none};
      rows[15] = '{8'h0F, 1'b0, none};
      rows[16] = '{8'hF0, 1'b0, none};
      rows[17] = '{8'h3C, 1'b0, none};
      rows[18] = '{8'hC3, 1'b0, none};
      rows[19] = '{8'h80, 1'b0, none};
      rows[20] = '{8'h12, 1'b0, none};
      rows[21] = '{8'h34, 1'b0, none};
      rows[22] = '{8'h56, 1'b0, none};
      rows[23] = '{8'h78, 1'b1, '{'{8'd1, 8'h78, 8'h12, 8'h34, 8'h56}, 1'b0}};

      // pixel count writes after image start must not disturb the image
      segs[0] = '{3'd3, 1'b1, 32'hFFFE_0001, 0,  0,  250, 0};
      segs[1] = '{3'd4, 1'b0, 32'd1,         62, 0,  200, 0};
      segs[2] = '{3'd7, 1'b1, 32'd0,         0,  62, 250, 0};
      segs[3] = '{3'd4, 1'b1, 32'd1000,      0,  0,  150, 300};
      segs[4] = '{3'd0, 1'b0, 32'd77,        10, 10, 150, 0};
      segs[5] = '{3'd4, 1'b1, 32'd5,         10, 10, 250, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: known bytes at the reset pixel format
      image_pixels = 32'd4000 + $urandom_range(0, 999);
      configure(3'd4, 1'b1, image_pixels);
      foreach (rows[i])
         send_code(rows[i].code, rows[i].typed, rows[i].run);
      quiesce();

      // random segments, stopping early once the image nears its end
      foreach (segs[s]) begin
         configure(segs[s].bpp, segs[s].rle, segs[s].pix_count);
         idle_pct  = segs[s].idle_pct;
         stall_pct = segs[s].stall_pct;
         if (segs[s].hold > 0) begin
            fork
               automatic int n = segs[s].hold;
               hold_receiver(n);
            join_none
         end
         for (k = 0; k < segs[s].n_codes && pixels_left > DrainFloor; k++)
            send_code(next_code(1'b0), 1'b0, none);
         quiesce();
      end

      // finish the image with long repeat packets, then feed bytes it must ignore
      configure(3'd3, 1'b1, 32'd1);
      idle_pct  = 10;
      stall_pct = 10;
      while (!image_done)
         send_code(next_code(1'b1), 1'b0, none);
      for (k = 0; k < 8; k++)
         send_code(8'($urandom_range(0, 255)), 1'b0, none);
      quiesce();

      $display("%0d code bytes, %0d runs checked (%0d repeat runs, %0d clipped final run)",
               codes_sent, runs_checked, repeat_runs, clipped_runs);
      $display("image of %0d pixels decoded in %0d cycles", image_pixels, cycle_count);
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
